// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared implication checks, clocked on clk and masked during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ttlhc_pkg.sv -----
// ----------------------------------------------------------------------------
// ttlhc_pkg
// types and constants of the expiring hash cache
// ----------------------------------------------------------------------------
package ttlhc_pkg;

	localparam int SLOTS_DEF        = 512;
	localparam int PROBE_WINDOW_DEF = 32;
	localparam int CAP_W            = 10;
	localparam int HASH_STEPS       = 8;
	localparam int DIV_STEPS        = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;
	localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h01000193;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	localparam logic [1:0] OUT_UPDATED = 2'd0;
	localparam logic [1:0] OUT_REUSED  = 2'd1;
	localparam logic [1:0] OUT_EVICTED = 2'd2;
	localparam logic [1:0] OUT_IGNORED = 2'd3;

	typedef struct packed {
		logic        func;
		logic [63:0] key;
		logic [31:0] host;
		logic [15:0] port;
		logic [31:0] ttl;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [31:0] host;
		logic [15:0] port;
		logic [31:0] expiry;
	} entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE,
		B_DONE
	} back_state_t;

endpackage

// ----- rtl/ttlhc_front.sv -----
// ----------------------------------------------------------------------------
// ttlhc_front
// takes a request, hashes the key and reduces it modulo the capacity
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttlhc_front #(
	parameter int SW = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ttlhc_pkg::req_t             req_in,
	input  logic [ttlhc_pkg::CAP_W-1:0] cap,
	input  logic                        hold,
	input  logic                        q_full,
	output logic                        push,
	output ttlhc_pkg::req_t             push_req,
	output logic [SW-1:0]               push_start
);
	import ttlhc_pkg::*;

	front_state_t state_q, state_d;
	req_t         req_q;
	logic [31:0]  h_q;
	logic [63:0]  key_sh_q;
	logic [CAP_W-1:0] rem_q;
	logic [4:0]   cnt_q;
	logic         accept;
	logic [CAP_W:0] trial;
	logic [CAP_W:0] diff;
	logic [31:0]  h_mix;

	assign accept = (state_q == F_IDLE) && in_valid && !hold;
	assign trial  = {rem_q, h_q[31]};
	assign diff   = trial - {1'b0, cap};
	assign h_mix  = (h_q ^ {24'd0, key_sh_q[7:0]}) * FNV_PRIME;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_HASH;
			end
			F_HASH: begin
				if (cnt_q == 5'(HASH_STEPS - 1)) state_d = F_MOD;
			end
			F_MOD: begin
				if (cnt_q == 5'(DIV_STEPS - 1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != F_IDLE) || hold;
		push     = (state_q == F_PUSH) && !q_full;
	end

	assign push_req   = req_q;
	assign push_start = SW'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else if (state_q == F_HASH || state_q == F_MOD) cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					req_q    <= req_in;
					h_q      <= FNV_BASIS;
					key_sh_q <= req_in.key;
					rem_q    <= '0;
				end
			end
			F_HASH: begin
				h_q      <= h_mix;
				key_sh_q <= key_sh_q >> 8;
			end
			F_MOD: begin
				// restoring remainder, one dividend bit per cycle
				h_q   <= h_q << 1;
				rem_q <= (trial >= {1'b0, cap}) ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	`CHK_IMPL(a_push_after_mod, push, $past(state_q) == F_MOD || $past(state_q) == F_PUSH, "push without reduction")

endmodule

// ----- rtl/ttlhc_fifo.sv -----
// ----------------------------------------------------------------------------
// ttlhc_fifo
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttlhc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] pdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	import ttlhc_pkg::*;

	logic [W-1:0] buf_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = buf_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wptr_q] <= pdata;
	end

	`CHK_IMPL(a_no_overflow, push, !full, "push into full queue")
	`CHK_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ----- rtl/ttlhc_back.sv -----
// ----------------------------------------------------------------------------
// ttlhc_back
// clears the slot table after reset, probes it, updates it and holds the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttlhc_back #(
	parameter int SLOTS        = 512,
	parameter int PROBE_WINDOW = 32,
	parameter int SW           = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ttlhc_pkg::CAP_W-1:0] cap,
	input  logic                        q_empty,
	input  ttlhc_pkg::req_t             q_req,
	input  logic [SW-1:0]               q_start,
	output logic                        pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [31:0]                 hit_host,
	output logic [15:0]                 hit_port,
	output logic [1:0]                  insert_outcome
);
	import ttlhc_pkg::*;

	localparam int NPW = $clog2(PROBE_WINDOW + 1);
	localparam int CLW = $clog2(SLOTS + 1);

	entry_t slot_mem [SLOTS];
	entry_t rd_q;

	back_state_t state_q, state_d;
	req_t        req_q;
	logic [31:0] exp_q;
	logic        is_write_q;
	logic [NPW-1:0] nprobe_q, iss_cnt_q, ev_cnt_q;
	logic [SW-1:0]  iss_slot_q, ev_slot_q, free_s_q, old_s_q, victim_q;
	logic        ev_v_q, have_free_q, have_old_q;
	logic [31:0] old_exp_q;
	logic        found_q;
	logic [31:0] host_q;
	logic [15:0] port_q;
	logic [1:0]  outc_q;
	logic [CLW-1:0] clr_q;
	logic        out_v_q, found_o_q;
	logic [31:0] host_o_q;
	logic [15:0] port_o_q;
	logic [1:0]  outc_o_q;

	logic        issue, out_load, we, live, match, last, finish;
	logic [SW-1:0] waddr, nxt_slot;
	entry_t      wdata;
	logic        have_free_n, have_old_n;
	logic [SW-1:0] free_s_n, old_s_n;
	logic [31:0] old_exp_n;
	logic [32:0] exp_sum;
	logic [NPW-1:0] nprobe_in;

	assign exp_sum   = {1'b0, q_req.now} + {1'b0, q_req.ttl};
	assign nprobe_in = ({22'd0, cap} < 32'(PROBE_WINDOW)) ? NPW'(cap) : NPW'(PROBE_WINDOW);
	assign nxt_slot  = (32'(iss_slot_q) + 32'd1 == {22'd0, cap}) ? '0 : iss_slot_q + SW'(1);

	assign live   = rd_q.valid && (rd_q.expiry > req_q.now);
	assign match  = live && (rd_q.key == req_q.key);
	assign last   = (ev_cnt_q + NPW'(1)) == nprobe_q;
	assign finish = ev_v_q && (match || last);

	// free or expired slot wins first, else the soonest-expiring live slot
	always_comb begin
		have_free_n = have_free_q;
		free_s_n    = free_s_q;
		have_old_n  = have_old_q;
		old_s_n     = old_s_q;
		old_exp_n   = old_exp_q;
		if (live) begin
			if (!have_old_q || rd_q.expiry < old_exp_q) begin
				have_old_n = 1'b1;
				old_s_n    = ev_slot_q;
				old_exp_n  = rd_q.expiry;
			end
		end else if (!have_free_q) begin
			have_free_n = 1'b1;
			free_s_n    = ev_slot_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: begin
				if (clr_q == CLW'(SLOTS - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!q_empty) begin
					if (q_req.func == FUNC_INSERT && q_req.ttl == 32'd0) state_d = B_DONE;
					else state_d = B_PROBE;
				end
			end
			B_PROBE: begin
				if (finish) state_d = B_DONE;
			end
			B_DONE: begin
				if (!out_v_q || !out_stall) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == B_IDLE) && !q_empty;
		clearing = (state_q == B_CLEAR);
		issue    = (state_q == B_PROBE) && (iss_cnt_q != nprobe_q);
		out_load = (state_q == B_DONE) && (!out_v_q || !out_stall);
		we       = clearing || (out_load && is_write_q);
		waddr    = clearing ? clr_q[SW-1:0] : victim_q;
		wdata    = clearing ? '0 : {1'b1, req_q.key, req_q.host, req_q.port, exp_q};
	end

	always_ff @(posedge clk) begin
		if (we) slot_mem[waddr] <= wdata;
		rd_q <= slot_mem[iss_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			ev_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + CLW'(1);
			ev_v_q <= issue;
			if (out_load) out_v_q <= 1'b1;
			else if (!out_stall) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ev_slot_q <= iss_slot_q;
		if (pop) begin
			req_q       <= q_req;
			exp_q       <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
			is_write_q  <= (q_req.func == FUNC_INSERT) && (q_req.ttl != 32'd0);
			nprobe_q    <= nprobe_in;
			iss_slot_q  <= q_start;
			iss_cnt_q   <= '0;
			ev_cnt_q    <= '0;
			have_free_q <= 1'b0;
			have_old_q  <= 1'b0;
			found_q     <= 1'b0;
			host_q      <= '0;
			port_q      <= '0;
			outc_q      <= (q_req.func == FUNC_INSERT && q_req.ttl == 32'd0) ?
				OUT_IGNORED : OUT_UPDATED;
		end
		if (issue) begin
			iss_slot_q <= nxt_slot;
			iss_cnt_q  <= iss_cnt_q + NPW'(1);
		end
		if (state_q == B_PROBE && ev_v_q) begin
			ev_cnt_q    <= ev_cnt_q + NPW'(1);
			have_free_q <= have_free_n;
			free_s_q    <= free_s_n;
			have_old_q  <= have_old_n;
			old_s_q     <= old_s_n;
			old_exp_q   <= old_exp_n;
			if (match) begin
				victim_q <= ev_slot_q;
				if (req_q.func == FUNC_LOOKUP) begin
					found_q <= 1'b1;
					host_q  <= rd_q.host;
					port_q  <= rd_q.port;
				end else begin
					outc_q <= OUT_UPDATED;
				end
			end else if (last && req_q.func == FUNC_INSERT) begin
				victim_q <= have_free_n ? free_s_n : old_s_n;
				outc_q   <= have_free_n ? OUT_REUSED : OUT_EVICTED;
			end
		end
		if (out_load) begin
			found_o_q <= found_q;
			host_o_q  <= host_q;
			port_o_q  <= port_q;
			outc_o_q  <= outc_q;
		end
	end

	assign out_valid      = out_v_q;
	assign found          = found_o_q;
	assign hit_host       = host_o_q;
	assign hit_port       = port_o_q;
	assign insert_outcome = outc_o_q;

	`CHK_IMPL(a_write_phase, we, state_q == B_DONE || state_q == B_CLEAR, "table write outside done or clear")
	`CHK_IMPL(a_eval_behind, state_q == B_PROBE, ev_cnt_q <= iss_cnt_q, "evaluated more slots than read")

endmodule

// ----- rtl/ttl_hash_cache_probe_window.sv -----
// ----------------------------------------------------------------------------
// ttl_hash_cache_probe_window
// keyed cache with expiry times over an open-addressing slot table
// ----------------------------------------------------------------------------
// channel  | handshake         | payload
// in       | in_valid/in_stall | func key host_in port_in ttl_ms now_ms
// out      | out_valid/out_stall | found hit_host hit_port insert_outcome
// cfg      | apb psel/penable  | capacity at byte 0
//
// front: accept, 8 hash rounds, 32 remainder bits, then a push once the queue has room
// back: pop, up to min(capacity, window) pipelined slot reads, then done
// after reset the table is cleared one slot a cycle, and no requests are taken
// a stalled result holds the back; the queue lets the front hash meanwhile
// ----------------------------------------------------------------------------
module ttl_hash_cache_probe_window #(
	parameter int SLOTS        = ttlhc_pkg::SLOTS_DEF,
	parameter int PROBE_WINDOW = ttlhc_pkg::PROBE_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] key,
	input  logic [31:0] host_in,
	input  logic [15:0] port_in,
	input  logic [31:0] ttl_ms,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] hit_host,
	output logic [15:0] hit_port,
	output logic [1:0]  insert_outcome
);
	import ttlhc_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int QW = $bits(req_t) + SW;

	logic [CAP_W-1:0] cap_q, cap_eff;
	req_t          in_req, push_req, q_req;
	logic [SW-1:0] push_start, q_start;
	logic          push, pop, q_full, q_empty, clearing;
	logic [QW-1:0] q_rdata;

	assign pready = 1'b1;
	assign prdata = {22'd0, cap_q};

	// single register, address bits are ignored: every address reads and writes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr <= 2'd3) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		if (cap_q == '0) cap_eff = CAP_W'(1);
		else if ({22'd0, cap_q} > 32'(SLOTS)) cap_eff = CAP_W'(SLOTS);
		else cap_eff = cap_q;
	end

	assign in_req = '{func: func, key: key, host: host_in, port: port_in,
		ttl: ttl_ms, now: now_ms};

	ttlhc_front #(.SW(SW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_in     (in_req),
		.cap        (cap_eff),
		.hold       (clearing),
		.q_full     (q_full),
		.push       (push),
		.push_req   (push_req),
		.push_start (push_start)
	);

	ttlhc_fifo #(.W(QW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pdata  ({push_start, push_req}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_req   = req_t'(q_rdata[$bits(req_t)-1:0]);
	assign q_start = q_rdata[QW-1 -: SW];

	ttlhc_back #(
		.SLOTS        (SLOTS),
		.PROBE_WINDOW (PROBE_WINDOW),
		.SW           (SW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cap            (cap_eff),
		.q_empty        (q_empty),
		.q_req          (q_req),
		.q_start        (q_start),
		.pop            (pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.hit_host       (hit_host),
		.hit_port       (hit_port),
		.insert_outcome (insert_outcome)
	);

endmodule
